// File: hw/rtl/satl_pkg.sv
// Shared types and constants of the set-associative tag lookup.
package satl_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned TagWidth   = 32;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned MaskWidth  = 8;
  localparam int unsigned StallWidth = 6;
  localparam int unsigned WayOutWidth = 2;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned LfsrWidth  = 16;

  localparam logic [StallWidth-1:0] MissStall = 6'd50;
  localparam logic [StallWidth-1:0] HitStall  = 6'd0;

  localparam logic [ShiftWidth-1:0] TagShiftReset   = 5'd13;
  localparam logic [ShiftWidth-1:0] IndexShiftReset = 5'd5;
  localparam logic [MaskWidth-1:0]  IndexMaskReset  = 8'd255;
  localparam logic [LfsrWidth-1:0]  LfsrReset       = 16'h0001;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TAG_SHIFT   = 2'd0,
    REG_INDEX_SHIFT = 2'd1,
    REG_INDEX_MASK  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ShiftWidth-1:0] tag_rshift;
    logic [ShiftWidth-1:0] index_shift;
    logic [MaskWidth-1:0]  index_mask;
  } cfg_t;

endpackage

// File: hw/rtl/satl_cfg_regs.sv
// Configuration registers written over the configuration channel.
module satl_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [satl_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [satl_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output satl_pkg::cfg_t                      cfg_o
);

  satl_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (satl_pkg::reg_idx_e'(cfg_index_i))
        satl_pkg::REG_TAG_SHIFT:   cfg_d.tag_rshift  = cfg_data_i[satl_pkg::ShiftWidth-1:0];
        satl_pkg::REG_INDEX_SHIFT: cfg_d.index_shift = cfg_data_i[satl_pkg::ShiftWidth-1:0];
        satl_pkg::REG_INDEX_MASK:  cfg_d.index_mask  = cfg_data_i[satl_pkg::MaskWidth-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_rshift  <= satl_pkg::TagShiftReset;
      cfg_q.index_shift <= satl_pkg::IndexShiftReset;
      cfg_q.index_mask  <= satl_pkg::IndexMaskReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/satl_row_ram.sv
// Synchronous set memory holding the valid bits and tags of one set per row.
module satl_row_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 132
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

endmodule

// File: hw/rtl/satl_victim.sv
// Replacement LFSR and the reduction of its stepped value to a way number.
module satl_victim #(
  parameter int unsigned Ways = 4,
  parameter int unsigned WayW = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  output logic [WayW-1:0] way_o
);

  localparam int unsigned ModW = 5;
  localparam logic [ModW:0] WaysC = (ModW+1)'(Ways);

  logic [satl_pkg::LfsrWidth-1:0] lfsr_d, lfsr_q;
  logic                           feedback;
  logic [ModW-1:0]                hi_mod [256];
  logic [ModW-1:0]                lo_mod [256];
  logic [ModW:0]                  mod_sum;
  logic [ModW:0]                  mod_red;

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign hi_mod[g] = ModW'((g * 256) % Ways);
    assign lo_mod[g] = ModW'(g % Ways);
  end

  assign feedback = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_d   = {feedback, lfsr_q[satl_pkg::LfsrWidth-1:1]};

  assign mod_sum = {1'b0, hi_mod[lfsr_d[15:8]]} + {1'b0, lo_mod[lfsr_d[7:0]]};
  assign mod_red = (mod_sum >= WaysC) ? (mod_sum - WaysC) : mod_sum;
  assign way_o   = mod_red[WayW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= satl_pkg::LfsrReset;
    end else if (step_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("replacement LFSR reached the all-zero state");

  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_red < WaysC) else $error("random way beyond the way count");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> lfsr_q == $past(lfsr_d)) else $error("LFSR did not take its next value");

endmodule

// File: hw/rtl/set_assoc_tag_lookup_random_replace.sv
// Result: an accepted address word moves to the lookup state, and its result word is
// registered once the output register is empty or being read. A new address word is taken
// only in idle, after the read of the set memory and the compare and miss write-back of the row.
// Reset: configuration, LFSR and handshake state clear at once; a clearing pass then
// zeroes the valid bits of the set memory, one row a cycle from row 0 to row SETS-1,
// while no address word is accepted.
module set_assoc_tag_lookup_random_replace #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [satl_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [satl_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [satl_pkg::AddrWidth-1:0]     address_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [satl_pkg::StallWidth-1:0]    stall_cycles_o,
  output logic [satl_pkg::WayOutWidth-1:0]   way_used_o
);

  localparam int unsigned IdxW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TagW = satl_pkg::TagWidth;
  localparam int unsigned RowW = WAYS * (TagW + 1);
  localparam logic [IdxW-1:0] LastSet = IdxW'(SETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  state_e state_d, state_q;

  satl_pkg::cfg_t cfg;

  logic [IdxW-1:0] set_mod [256];
  logic [IdxW-1:0] clr_d, clr_q;
  logic [IdxW-1:0] set_in;
  logic [IdxW-1:0] set_d, set_q;
  logic [satl_pkg::AddrWidth-1:0] addr_d, addr_q;
  logic [satl_pkg::AddrWidth-1:0] idx_shifted;
  logic [satl_pkg::MaskWidth-1:0] idx_masked;
  logic [TagW-1:0] tag;

  logic            accept;
  logic            done;
  logic            rd_en;
  logic [RowW-1:0] rd_row;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [RowW-1:0] wr_row;

  logic [WAYS-1:0]           row_valid;
  logic [WAYS-1:0][TagW-1:0] row_tag;
  logic [WAYS-1:0]           match;
  logic [WAYS-1:0]           new_valid;
  logic [WAYS-1:0][TagW-1:0] new_tag;
  logic                      any_hit;
  logic                      all_valid;
  logic [WayW-1:0]           hit_way;
  logic [WayW-1:0]           free_way;
  logic [WayW-1:0]           rand_way;
  logic [WayW-1:0]           sel_way;
  logic [WayW+1:0]           sel_way_ext;
  logic                      lfsr_step;

  logic                            out_valid_d, out_valid_q;
  logic                            hit_d, hit_q;
  logic [satl_pkg::StallWidth-1:0] stall_d, stall_q;
  logic [satl_pkg::WayOutWidth-1:0] way_d, way_q;

  for (genvar g = 0; g < 256; g++) begin : g_set_mod
    assign set_mod[g] = IdxW'(g % SETS);
  end

  satl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  satl_row_ram #(
    .Depth (SETS),
    .AddrW (IdxW),
    .DataW (RowW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (set_in),
    .rd_data_o (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_row)
  );

  satl_victim #(
    .Ways (WAYS),
    .WayW (WayW)
  ) u_victim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (lfsr_step),
    .way_o  (rand_way)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign rd_en       = accept;
  assign idx_shifted = address_i >> cfg.index_shift;
  assign idx_masked  = idx_shifted[satl_pkg::MaskWidth-1:0] & cfg.index_mask;
  assign set_in      = set_mod[idx_masked];
  assign tag         = addr_q >> cfg.tag_rshift;
  assign done        = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  always_comb begin
    row_valid = rd_row[WAYS*TagW +: WAYS];
    for (int w = 0; w < WAYS; w++) begin
      row_tag[w] = rd_row[w*TagW +: TagW];
      match[w]   = row_valid[w] && (row_tag[w] == tag);
    end
    any_hit   = |match;
    all_valid = &row_valid;
    hit_way   = '0;
    free_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WayW'(w);
      end
      if (!row_valid[w]) begin
        free_way = WayW'(w);
      end
    end
    if (any_hit) begin
      sel_way = hit_way;
    end else if (all_valid) begin
      sel_way = rand_way;
    end else begin
      sel_way = free_way;
    end
    for (int w = 0; w < WAYS; w++) begin
      new_valid[w] = row_valid[w] || (sel_way == WayW'(w));
      new_tag[w]   = (sel_way == WayW'(w)) ? tag : row_tag[w];
    end
  end

  assign lfsr_step   = done && !any_hit && all_valid;
  assign sel_way_ext = {2'b00, sel_way};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    set_d       = set_q;
    addr_d      = addr_q;
    wr_en       = 1'b0;
    wr_addr     = set_q;
    wr_row      = {new_valid, new_tag};
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    stall_d     = stall_q;
    way_d       = way_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastSet) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          set_d   = set_in;
          addr_d  = address_i;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          wr_en       = !any_hit;
          out_valid_d = 1'b1;
          hit_d       = any_hit;
          stall_d     = any_hit ? satl_pkg::HitStall : satl_pkg::MissStall;
          way_d       = sel_way_ext[satl_pkg::WayOutWidth-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q   <= set_d;
    addr_q  <= addr_d;
    hit_q   <= hit_d;
    stall_q <= stall_d;
    way_q   <= way_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign stall_cycles_o = stall_q;
  assign way_used_o     = way_q;

  a_stall_matches_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o ? (stall_cycles_o == satl_pkg::HitStall)
                           : (stall_cycles_o == satl_pkg::MissStall)))
    else $error("stall count disagrees with the hit flag");

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("accepted word did not start a lookup");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == ST_CLEAR) || (done && !any_hit)))
    else $error("set memory written outside a clear or a miss fill");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o)
    else $error("finished lookup left no result word");

endmodule
